// ===== rtl/mss_pkg.sv =====
// Shared types, codes and helpers for the match span segmenter.
package mss_pkg;

    localparam int OFS_W = 21;
    localparam int CFG_DATA_W = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int unsigned MAX_TEXT_LENGTH = 1048576;
    localparam int unsigned OFS_LIMIT = (1 << OFS_W) - 1;
    localparam int CMDQ_DEPTH = 2;

    typedef logic [OFS_W-1:0] ofs_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT     = 1'b1;

    // item kinds
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // split modes; codes 5..7 are unused
    localparam logic [2:0] MODE_REMOVED    = 3'd0;
    localparam logic [2:0] MODE_ISOLATED   = 3'd1;
    localparam logic [2:0] MODE_MERGE_PREV = 3'd2;
    localparam logic [2:0] MODE_MERGE_NEXT = 3'd3;
    localparam logic [2:0] MODE_CONTIGUOUS = 3'd4;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    typedef struct packed {
        logic vld;
        ofs_t start;
        ofs_t len;
    } seg_t;

    // seg0 always holds the first segment; seg1 only the second one
    typedef struct packed {
        seg_t seg0;
        seg_t seg1;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic ofs_t sat_ofs(input ofs_t v);
        ofs_t r;
        r = v;
        if (MAX_TEXT_LENGTH < OFS_LIMIT && 32'(v) > MAX_TEXT_LENGTH)
        begin
            r = OFS_W'(MAX_TEXT_LENGTH);
        end
        return r;
    endfunction

    function automatic seg_t mk_seg(input ofs_t a, input ofs_t b);
        seg_t s;
        s.vld   = (b > a);
        s.start = a;
        s.len   = b - a;
        return s;
    endfunction

endpackage

// ===== rtl/mss_front.sv =====
// Front end: config registers, per-text state and segment classification.
module mss_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    input  logic                             kind,
    input  mss_pkg::ofs_t                    match_start,
    input  mss_pkg::ofs_t                    match_end,
    input  mss_pkg::ofs_t                    text_length,
    output logic                             q_push,
    output mss_pkg::cmd_t                    q_cmd
);

    logic [2:0]    split_mode_reg;
    logic          invert_reg;
    mss_pkg::ofs_t cursor_reg, cursor_next;
    logic          pend_vld_reg, pend_vld_next;
    mss_pkg::ofs_t pend_start_reg, pend_start_next;
    mss_pkg::ofs_t run_end_reg, run_end_next;

    mss_pkg::ofs_t ms, me, tlen;
    mss_pkg::seg_t seg_a, seg_b;

    always_comb
    begin
        ms   = mss_pkg::sat_ofs(match_start);
        me   = mss_pkg::sat_ofs(match_end);
        tlen = mss_pkg::sat_ofs(text_length);

        cursor_next     = cursor_reg;
        pend_vld_next   = pend_vld_reg;
        pend_start_next = pend_start_reg;
        run_end_next    = run_end_reg;
        seg_a           = '0;
        seg_b           = '0;

        if (accept)
        begin
            if (kind == mss_pkg::KIND_MATCH)
            begin
                if (invert_reg)
                begin
                    seg_a = mss_pkg::mk_seg(ms, me);
                end
                else
                begin
                    case (split_mode_reg)
                        mss_pkg::MODE_REMOVED:
                        begin
                            seg_a       = mss_pkg::mk_seg(cursor_reg, ms);
                            cursor_next = me;
                        end
                        mss_pkg::MODE_ISOLATED:
                        begin
                            seg_a       = mss_pkg::mk_seg(cursor_reg, ms);
                            seg_b       = mss_pkg::mk_seg(ms, me);
                            cursor_next = me;
                        end
                        mss_pkg::MODE_MERGE_PREV:
                        begin
                            seg_a       = mss_pkg::mk_seg(cursor_reg, me);
                            cursor_next = me;
                        end
                        mss_pkg::MODE_MERGE_NEXT:
                        begin
                            seg_a = mss_pkg::mk_seg(pend_vld_reg ? pend_start_reg : '0, ms);
                            pend_start_next = ms;
                            pend_vld_next   = 1'b1;
                            cursor_next     = me;
                        end
                        mss_pkg::MODE_CONTIGUOUS:
                        begin
                            if (pend_vld_reg && ms == run_end_reg)
                            begin
                                // match touches the held run: grow it
                                run_end_next = me;
                            end
                            else
                            begin
                                if (pend_vld_reg)
                                begin
                                    seg_a = mss_pkg::mk_seg(pend_start_reg, run_end_reg);
                                end
                                seg_b           = mss_pkg::mk_seg(cursor_reg, ms);
                                pend_start_next = ms;
                                run_end_next    = me;
                                pend_vld_next   = 1'b1;
                            end
                            cursor_next = me;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else
            begin
                if (!invert_reg)
                begin
                    case (split_mode_reg)
                        mss_pkg::MODE_REMOVED,
                        mss_pkg::MODE_ISOLATED,
                        mss_pkg::MODE_MERGE_PREV:
                        begin
                            seg_a = mss_pkg::mk_seg(cursor_reg, tlen);
                        end
                        mss_pkg::MODE_MERGE_NEXT:
                        begin
                            seg_a = mss_pkg::mk_seg(pend_vld_reg ? pend_start_reg : '0, tlen);
                        end
                        mss_pkg::MODE_CONTIGUOUS:
                        begin
                            if (pend_vld_reg)
                            begin
                                seg_a = mss_pkg::mk_seg(pend_start_reg, run_end_reg);
                            end
                            seg_b = mss_pkg::mk_seg(cursor_reg, tlen);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // end of text: clear for the next one
                cursor_next     = '0;
                pend_vld_next   = 1'b0;
                pend_start_next = '0;
                run_end_next    = '0;
            end
        end

        // pack so the first live segment sits in seg0
        q_cmd.seg0 = seg_a.vld ? seg_a : seg_b;
        q_cmd.seg1 = seg_a.vld ? seg_b : '0;
        q_push     = seg_a.vld | seg_b.vld;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_reg <= mss_pkg::MODE_REMOVED;
            invert_reg     <= 1'b0;
            cursor_reg     <= '0;
            pend_vld_reg   <= 1'b0;
            pend_start_reg <= '0;
            run_end_reg    <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == mss_pkg::REG_SPLIT_MODE)
            begin
                split_mode_reg <= cfg_data[2:0];
            end
            if (cfg_write && cfg_index == mss_pkg::REG_INVERT)
            begin
                invert_reg <= cfg_data[0];
            end
            cursor_reg     <= cursor_next;
            pend_vld_reg   <= pend_vld_next;
            pend_start_reg <= pend_start_next;
            run_end_reg    <= run_end_next;
        end
    end

endmodule

// ===== rtl/mss_cmdq.sv =====
// Small command queue between front and back end.
module mss_cmdq
#(
    parameter int DEPTH = mss_pkg::CMDQ_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_push,
    input  mss_pkg::cmd_t  q_wdata,
    input  logic           q_pop,
    output mss_pkg::cmd_t  q_rdata,
    output mss_pkg::qstat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mss_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_rdata      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (q_pop && !q_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mss_back.sv =====
// Back end: issues one segment per cycle into the output register while it is free or being popped.
module mss_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  mss_pkg::qstat_t q_stat,
    input  mss_pkg::cmd_t   q_rdata,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output mss_pkg::ofs_t   segment_start,
    output mss_pkg::ofs_t   segment_length,
    output logic            last
);

    mss_pkg::phase_t phase_reg, phase_next;
    logic            out_vld_reg, out_vld_next;
    mss_pkg::ofs_t   out_start_reg, out_len_reg;
    logic            out_last_reg;

    logic            load;
    mss_pkg::seg_t   sel;
    logic            sel_last;
    logic            out_free;

    always_comb
    begin
        out_free   = !out_vld_reg || pop;
        phase_next = phase_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        sel        = q_rdata.seg0;
        sel_last   = 1'b1;

        case (phase_reg)
            mss_pkg::PH_FIRST:
            begin
                if (!q_stat.empty && out_free)
                begin
                    load     = 1'b1;
                    sel      = q_rdata.seg0;
                    sel_last = !q_rdata.seg1.vld;
                    if (q_rdata.seg1.vld)
                    begin
                        phase_next = mss_pkg::PH_SECOND;
                    end
                    else
                    begin
                        q_pop = 1'b1;
                    end
                end
            end
            mss_pkg::PH_SECOND:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    sel        = q_rdata.seg1;
                    sel_last   = 1'b1;
                    q_pop      = 1'b1;
                    phase_next = mss_pkg::PH_FIRST;
                end
            end
            default:
            begin
                phase_next = mss_pkg::PH_FIRST;
            end
        endcase

        out_vld_next = load | (out_vld_reg & !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mss_pkg::PH_FIRST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_start_reg <= sel.start;
            out_len_reg   <= sel.len;
            out_last_reg  <= sel_last;
        end
    end

    assign empty          = !out_vld_reg;
    assign segment_start  = out_start_reg;
    assign segment_length = out_len_reg;
    assign last           = out_last_reg;

endmodule

// ===== rtl/match_span_segmenter_unit.sv =====
// Top level of the match span segmenter.
//
// Usage: write split_mode (index 0) and invert_matches (index 1) through
// cfg_write/cfg_index/cfg_data while the block is idle. Then push delimiter
// matches (kind 0, ascending offsets) followed by one end item (kind 1,
// text_length). An item enters when push is high and full is low.
// Segments come out queue style: while empty is low, segment_start,
// segment_length and last show the oldest segment; pop takes it. last marks
// the final segment caused by one item; items that cause none emit nothing.
// Path: the first segment of an item passes through the command queue and
// then the output register before it is on the ports; a second one follows
// in the next cycle when the first is popped at once.
// Throughput: the front end takes one item per clock while full is low; the
// back end moves one segment per clock through a single output register
// while the sink pops, so an item causing two segments holds it longer than others.
// Reset: config goes to removed mode without invert, per-text state clears,
// the command queue and output register are empty.
// Stall: when pop stays low the output register holds, the command queue
// (CMDQ_DEPTH commands) fills, and full rises until the sink drains it.
module match_span_segmenter_unit
#(
    parameter int CMDQ_DEPTH = mss_pkg::CMDQ_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             kind,
    input  logic [20:0]                      match_start,
    input  logic [20:0]                      match_end,
    input  logic [20:0]                      text_length,
    output logic                             empty,
    input  logic                             pop,
    output logic [20:0]                      segment_start,
    output logic [20:0]                      segment_length,
    output logic                             last
);

    logic            accept;
    logic            q_push;
    logic            q_pop;
    mss_pkg::cmd_t   q_wdata;
    mss_pkg::cmd_t   q_rdata;
    mss_pkg::qstat_t q_stat;

    // front stalls only on a full command queue
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    mss_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .kind        (kind),
        .match_start (match_start),
        .match_end   (match_end),
        .text_length (text_length),
        .q_push      (q_push),
        .q_cmd       (q_wdata)
    );

    mss_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_stat  (q_stat)
    );

    mss_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .segment_start  (segment_start),
        .segment_length (segment_length),
        .last           (last)
    );

    // zero-length segments must have been dropped in the front end
    a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> segment_length != '0)
        else $error("segment of zero length on the output");

    // front end never writes into a full command queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue overflow");

    // back end never retires a command that is not there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command queue underflow");

endmodule

// ===== tb/sv/mss_segment_checker.sv =====
// Checker for the match span segmenter: predicts segments per item and compares them.
module mss_segment_checker
    import mss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  logic                   full,
    input  logic                   kind,
    input  logic [20:0]            match_start,
    input  logic [20:0]            match_end,
    input  logic [20:0]            text_length,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [20:0]            segment_start,
    input  logic [20:0]            segment_length,
    input  logic                   last,
    output int                     errors,
    output int                     waiting,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ofs_t start;
        ofs_t len;
        logic last;
    } segment_t;

    segment_t expected_segments[$];
    segment_t item_segs[2];
    int       item_seg_count = 0;

    // shadow configuration and per-text state
    logic [2:0] split_mode_r = MODE_REMOVED;
    logic       invert_r     = 1'b0;
    ofs_t       gap_cursor   = '0;
    logic       held_valid   = 1'b0;
    ofs_t       held_start   = '0;
    ofs_t       held_run_end = '0;

    int error_count   = 0;
    int checked_count = 0;

    function automatic ofs_t clamp_offset(input ofs_t v);
        ofs_t top;
        top = ofs_t'(MAX_TEXT_LENGTH);
        return (v > top) ? top : v;
    endfunction

    // record [a, b) as a segment unless it is empty or backward
    task automatic add_span(input ofs_t a, input ofs_t b);
        if (b > a && item_seg_count < 2)
        begin
            item_segs[item_seg_count].start = a;
            item_segs[item_seg_count].len   = b - a;
            item_segs[item_seg_count].last  = 1'b0;
            item_seg_count++;
        end
    endtask

    task automatic predict_segments(input logic k, input ofs_t ms_raw, input ofs_t me_raw,
                                    input ofs_t tl_raw);
        ofs_t ms;
        ofs_t me;
        ofs_t tl;
        ofs_t cur;
        ofs_t ps;
        ofs_t re;
        item_seg_count = 0;
        cur = gap_cursor;
        ps  = held_start;
        re  = held_run_end;
        if (k == KIND_MATCH)
        begin
            ms = clamp_offset(ms_raw);
            me = clamp_offset(me_raw);
            if (invert_r)
            begin
                add_span(ms, me);
            end
            else
            begin
                case (split_mode_r)
                    MODE_REMOVED:
                    begin
                        add_span(cur, ms);
                        gap_cursor = me;
                    end
                    MODE_ISOLATED:
                    begin
                        add_span(cur, ms);
                        add_span(ms, me);
                        gap_cursor = me;
                    end
                    MODE_MERGE_PREV:
                    begin
                        add_span(cur, me);
                        gap_cursor = me;
                    end
                    MODE_MERGE_NEXT:
                    begin
                        add_span(held_valid ? ps : ofs_t'(0), ms);
                        held_start = ms;
                        held_valid = 1'b1;
                        gap_cursor = me;
                    end
                    MODE_CONTIGUOUS:
                    begin
                        if (held_valid && ms == re)
                        begin
                            held_run_end = me;
                        end
                        else
                        begin
                            if (held_valid)
                            begin
                                add_span(ps, re);
                            end
                            add_span(cur, ms);
                            held_start   = ms;
                            held_run_end = me;
                            held_valid   = 1'b1;
                        end
                        gap_cursor = me;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            tl = clamp_offset(tl_raw);
            if (!invert_r)
            begin
                case (split_mode_r)
                    MODE_REMOVED, MODE_ISOLATED, MODE_MERGE_PREV:
                    begin
                        add_span(cur, tl);
                    end
                    MODE_MERGE_NEXT:
                    begin
                        add_span(held_valid ? ps : ofs_t'(0), tl);
                    end
                    MODE_CONTIGUOUS:
                    begin
                        if (held_valid)
                        begin
                            add_span(ps, re);
                        end
                        add_span(cur, tl);
                    end
                    default:
                    begin
                    end
                endcase
            end
            gap_cursor   = '0;
            held_valid   = 1'b0;
            held_start   = '0;
            held_run_end = '0;
        end
        if (item_seg_count > 0)
        begin
            item_segs[item_seg_count-1].last = 1'b1;
        end
        for (int i = 0; i < item_seg_count; i++)
        begin
            expected_segments.push_back(item_segs[i]);
        end
    endtask

    task automatic compare_segment();
        segment_t exp_seg;
        if (expected_segments.size() == 0)
        begin
            $display("%0t: unexpected segment start=%0d length=%0d last=%0b",
                     $time, segment_start, segment_length, last);
            error_count++;
        end
        else
        begin
            exp_seg = expected_segments.pop_front();
            checked_count++;
            if (segment_start !== exp_seg.start)
            begin
                $display("%0t: segment_start expected %0d actual %0d",
                         $time, exp_seg.start, segment_start);
                error_count++;
            end
            if (segment_length !== exp_seg.len)
            begin
                $display("%0t: segment_length expected %0d actual %0d",
                         $time, exp_seg.len, segment_length);
                error_count++;
            end
            if (last !== exp_seg.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, exp_seg.last, last);
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_r = MODE_REMOVED;
            invert_r     = 1'b0;
            gap_cursor   = '0;
            held_valid   = 1'b0;
            held_start   = '0;
            held_run_end = '0;
            expected_segments.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SPLIT_MODE: split_mode_r = cfg_data[2:0];
                    REG_INVERT:     invert_r     = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (pop && !empty)
            begin
                compare_segment();
            end
            if (push && !full)
            begin
                predict_segments(kind, match_start, match_end, text_length);
            end
        end
        // outputs move after the edge so the stimulus side reads them race free
        errors  <= error_count;
        waiting <= expected_segments.size();
        checked <= checked_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives matches, end items and register writes into the segmenter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mss_pkg::*;

    localparam int OFS_TOP      = 2097151;  // largest 21-bit offset
    localparam int ITEM_TARGET  = 1100;     // random items after the directed part
    localparam int HOLD_CYCLES  = 400;      // long sink hold-off to fill the block
    localparam int SETTLE       = 8;        // lets an item with no segment finish
    localparam int STALL_LIMIT  = 4000;     // cycles without any transfer
    localparam int TAIL_CYCLES  = 20;
    localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;  // highest unused mode code

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   push        = 1'b0;
    logic                   kind        = KIND_MATCH;
    logic [20:0]            match_start = '0;
    logic [20:0]            match_end   = '0;
    logic [20:0]            text_length = '0;
    logic                   pop         = 1'b0;
    logic                   full;
    logic                   empty;
    logic [20:0]            segment_start;
    logic [20:0]            segment_length;
    logic                   last;

    int errors;
    int waiting;
    int checked;

    int items_sent    = 0;
    int phases        = 0;
    int quiet_cycles  = 0;
    int hold_requests = 0;  // bumped by the stimulus, served by the sink
    int holds_served  = 0;
    int hold_left     = 0;
    bit steady        = 1'b0; // no idling on either side while set

    match_span_segmenter_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .match_start    (match_start),
        .match_end      (match_end),
        .text_length    (text_length),
        .empty          (empty),
        .pop            (pop),
        .segment_start  (segment_start),
        .segment_length (segment_length),
        .last           (last)
    );

    mss_segment_checker segment_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .match_start    (match_start),
        .match_end      (match_end),
        .text_length    (text_length),
        .empty          (empty),
        .pop            (pop),
        .segment_start  (segment_start),
        .segment_length (segment_length),
        .last           (last),
        .errors         (errors),
        .waiting        (waiting),
        .checked        (checked)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: any stretch with no item moving on either side is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d segments still due",
                     $time, quiet_cycles, waiting);
            $display("Some tests failed");
            $finish;
        end
    end

    // Sink: pops at random, or holds off for a long count when asked so that
    // the block fills and raises full while the source keeps offering.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= steady || ($urandom_range(99) >= 11);
            end
        end
    end

    // Offer one item and wait until the block takes it. push stays high into
    // the next call unless that call idles first.
    task automatic send_item(input logic k, input logic [20:0] ms, input logic [20:0] me,
                             input logic [20:0] tl);
        while (!steady && $urandom_range(99) < 11)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        kind        <= k;
        match_start <= ms;
        match_end   <= me;
        text_length <= tl;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_match(input int ms, input int me);
        send_item(KIND_MATCH, 21'(ms), 21'(me), 21'($urandom));
    endtask

    task automatic send_end(input int tl);
        send_item(KIND_END, 21'($urandom), 21'($urandom), 21'(tl));
    endtask

    // Source pauses until every predicted segment has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Registers change only with the block idle; per-text state is kept, so a
    // text left open continues under the new mode.
    task automatic set_config(input logic [2:0] mode, input logic inv);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_SPLIT_MODE, mode);
        // upper data bits are don't-care for the invert flag
        write_reg(REG_INVERT, {2'($urandom), inv});
        cfg_write <= 1'b0;
        phases++;
    endtask

    // One text of ascending matches with random content: touching runs, empty
    // matches, the odd backward or overlapping match, then usually an end item.
    task automatic gen_text(input int n_match, input bit finish_text, input bit wide);
        int pos;
        int ms;
        int me;
        int gap;
        int span;
        int tl;
        int r;
        pos = $urandom_range(3);
        for (int i = 0; i < n_match; i++)
        begin
            r = $urandom_range(99);
            if (wide && r < 40)
            begin
                gap = $urandom_range(400000);
            end
            else if (r < 55)
            begin
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(1, 20);
            end
            span = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 12);
            ms = pos + gap;
            me = ms + span;
            if ($urandom_range(99) < 8)
            begin
                if ($urandom_range(1) == 1)
                begin
                    // backward match
                    me = (ms > 3) ? ms - $urandom_range(1, 3) : ms;
                end
                else
                begin
                    // overlaps the previous match
                    ms = (pos > 2) ? pos - $urandom_range(1, 2) : pos;
                end
            end
            if (ms > OFS_TOP)
            begin
                ms = OFS_TOP;
            end
            if (me > OFS_TOP)
            begin
                me = OFS_TOP;
            end
            send_match(ms, me);
            if (me > pos)
            begin
                pos = me;
            end
        end
        if (finish_text)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                tl = pos + $urandom_range(30);
            end
            else if (r < 92)
            begin
                tl = (pos > 0) ? $urandom_range(pos - 1) : 0;
            end
            else
            begin
                tl = $urandom_range(OFS_TOP);
            end
            if (tl > OFS_TOP)
            begin
                tl = OFS_TOP;
            end
            send_end(tl);
        end
    endtask

    initial
    begin
        int r;
        int n_texts;
        int random_start;
        logic [2:0] mode;
        logic inv;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset config: removed mode, empty match at zero.
        send_match(0, 0);
        send_match(4, 6);
        send_end(10);

        // isolated: touching matches, backward span, saturated end length
        set_config(MODE_ISOLATED, 1'b0);
        send_match(0, 3);
        send_match(3, 7);
        send_match(9, 8);
        send_end(OFS_TOP);

        // merged previous: offsets past the maximum get clamped
        set_config(MODE_MERGE_PREV, 1'b0);
        send_match(2, 4);
        send_match(MAX_TEXT_LENGTH, OFS_TOP);
        send_end(MAX_TEXT_LENGTH);

        // merged next, then a switch to contiguous in the middle of a text
        set_config(MODE_MERGE_NEXT, 1'b0);
        send_match(1, 2);
        send_match(5, 9);
        set_config(MODE_CONTIGUOUS, 1'b0);
        send_match(9, 12);
        send_match(12, 12);
        send_match(15, 16);
        send_end(20);

        // invert: matches only, backward one suppressed
        set_config(MODE_CONTIGUOUS, 1'b1);
        send_match(3, 6);
        send_match(6, 3);
        send_end(50);

        // unused mode code: nothing out, end still clears
        set_config(MODE_UNUSED_TOP, 1'b0);
        send_match(1, 2);
        send_end(9);
        set_config(MODE_REMOVED, 1'b0);
        send_match(0, OFS_TOP);
        send_end(0);

        // Random part
        random_start = items_sent;
        while (items_sent - random_start < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            mode = (r < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
            inv = ($urandom_range(99) < 20);
            // the stall phase needs a mode that puts segments out
            if (phases == 11)
            begin
                mode = MODE_ISOLATED;
                inv  = 1'b0;
            end
            set_config(mode, inv);

            // long sink hold-off once, source keeps going into full
            if (phases == 12)
            begin
                hold_requests++;
                gen_text(8, 1'b1, 1'b0);
            end
            // one stretch without idling on either side
            steady = (items_sent - random_start > 450 && items_sent - random_start < 650);

            n_texts = $urandom_range(1, 4);
            for (int t = 0; t < n_texts; t++)
            begin
                if ($urandom_range(99) < 12)
                begin
                    send_item(1'($urandom), 21'($urandom), 21'($urandom), 21'($urandom));
                end
                gen_text($urandom_range(8), (t < n_texts - 1) || ($urandom_range(99) >= 20),
                         $urandom_range(99) < 10);
            end
        end
        steady = 1'b0;

        // drain, then give any late extra segment a chance to show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d items over %0d register settings, all split modes with invert",
                 items_sent, phases);
        $display("on and off, including a full-block stall; %0d segments compared.", checked);
        if (errors == 0 && waiting == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches, %0d segments never arrived", errors, waiting);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
